// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Same-cycle implication that also holds through reset.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("reset-time check failed");

`endif

// File: rtl/lkvc_pkg.sv
// Package for the LRU key/value cache: sizes, widths and operation codes.
// No dependencies; used by the top level and its checker.
package lkvc_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int CAP_RESET   = 16;

    localparam logic [DATA_W-1:0] MISS_VALUE = '1;
    localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

endpackage

// File: rtl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
// Depends on lkvc_pkg.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/s_axis_tready tuser: operation; tdata: key, write_value
//  m_axis    out  m_axis_tvalid/m_axis_tready tuser: hit; tdata: read_value
//  cfg       in   i_cfg_we                    i_cfg_wdata: active_capacity
//
// One item per cycle while the output does not stall: an item sits in the input
// register while the parallel key compare across all 16 entries runs, and the
// rank update is applied as the result lands in the output register.
// Reset (synchronous, active low) empties the store at once and sets the
// capacity to 16. A stalled output holds the input register; the input side takes
// a transfer while that register is empty or the output is free or draining.
module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CAP_W-1:0]    i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [2*DATA_W-1:0] s_axis_tdata,   // [31:0] key, [63:32] write_value
    input  logic                s_axis_tuser,   // [0] operation
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [DATA_W-1:0]   m_axis_tdata,   // [31:0] read_value
    output logic                m_axis_tuser    // [0] hit
);

    logic [CAP_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_count;
    logic [NUM_ENTRIES-1:0] r_valid;
    logic [DATA_W-1:0] r_key  [NUM_ENTRIES];
    logic [DATA_W-1:0] r_val  [NUM_ENTRIES];
    logic [IDX_W-1:0]  r_rank [NUM_ENTRIES];

    logic              r_in_valid;
    t_op               r_in_op;
    logic [DATA_W-1:0] r_in_key;
    logic [DATA_W-1:0] r_in_wval;

    logic              r_out_valid;
    logic              r_out_hit;
    logic [DATA_W-1:0] r_out_data;

    logic              n_out_hit;
    logic [DATA_W-1:0] n_out_data;

    logic              step;
    logic [CNT_W-1:0]  eff_cap;
    logic              cap_zero;
    logic              is_put;
    logic              full;
    logic              hit_found;
    logic [IDX_W-1:0]  hit_slot;
    logic [IDX_W-1:0]  free_slot;
    logic [IDX_W-1:0]  victim_slot;
    logic [IDX_W-1:0]  victim_rank;
    logic [IDX_W-1:0]  slot;
    logic [IDX_W-1:0]  limit;
    logic              age_all;
    logic              upd;
    logic              write_kv;
    logic              fill;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    assign eff_cap  = (r_cap > CAP_W'(NUM_ENTRIES)) ? CNT_W'(NUM_ENTRIES)
                                                    : CNT_W'(r_cap);
    assign cap_zero = (eff_cap == '0);
    assign is_put   = (r_in_op == OP_PUT);
    assign full     = (r_count >= eff_cap);
    assign victim_rank = IDX_W'(r_count - CNT_W'(1));

    // Lowest-index match, free entry and victim; loops run high to low.
    always_comb begin
        hit_found   = 1'b0;
        hit_slot    = '0;
        free_slot   = '0;
        victim_slot = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_key[i] == r_in_key) begin
                hit_found = 1'b1;
                hit_slot  = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_slot = IDX_W'(i);
            end
            if (r_valid[i] && r_rank[i] == victim_rank) begin
                victim_slot = IDX_W'(i);
            end
        end
    end

    always_comb begin
        upd      = step && !cap_zero && (hit_found || is_put);
        write_kv = step && !cap_zero && is_put;
        fill     = write_kv && !hit_found && !full;
        age_all  = fill;
        if (hit_found) begin
            slot  = hit_slot;
            limit = r_rank[hit_slot];
        end else if (full) begin
            slot  = victim_slot;
            limit = victim_rank;
        end else begin
            slot  = free_slot;
            limit = '0;
        end
    end

    always_comb begin
        n_out_hit = !cap_zero && hit_found;
        if (is_put) begin
            n_out_data = PUT_VALUE;
        end else if (n_out_hit) begin
            n_out_data = r_val[hit_slot];
        end else begin
            n_out_data = MISS_VALUE;
        end
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_W'(CAP_RESET);
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Input register: load on a transfer, drop once processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= t_op'(s_axis_tuser);
            r_in_key  <= s_axis_tdata[DATA_W-1:0];
            r_in_wval <= s_axis_tdata[2*DATA_W-1:DATA_W];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_hit  <= n_out_hit;
            r_out_data <= n_out_data;
        end
    end

    // Entry state: valid bits, ranks and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (fill) begin
                r_valid[slot] <= 1'b1;
                r_count       <= r_count + CNT_W'(1);
            end
            if (upd) begin
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (IDX_W'(i) == slot) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (age_all || r_rank[i] < limit)) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (write_kv) begin
            r_key[slot] <= r_in_key;
            r_val[slot] <= r_in_wval;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_hit;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: rtl/lkvc_checker.sv
// Port-level checker for the LRU key/value cache, bound to the top level.
// Depends on lkvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lkvc_checker
    import lkvc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tready,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [DATA_W-1:0]   m_axis_tdata,   // [31:0] read_value
    input  logic                m_axis_tuser    // [0] hit
);

    // A stalled result holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A miss carries either the miss marker or the put result.
    `ASSERT_IMPLY(a_miss_data, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == MISS_VALUE || m_axis_tdata == PUT_VALUE)

    // Input back-pressure only while a result waits downstream.
    `ASSERT_IMPLY(a_ready_low, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid)

    // No result right after reset.
    `ASSERT_ALWAYS(a_reset_empty, i_clk, $rose(i_rst_n), !m_axis_tvalid)

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

// File: tb/sv/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache: directed and random get/put traffic,
// with a scoreboard that tracks keys, values and LRU ranks for each transfer.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
module lru_key_value_cache_tb
    import lkvc_pkg::*;
();

    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 150;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] value;
    } t_reply;

    class t_cache_scoreboard;
        logic [DATA_W-1:0] slot_key   [NUM_ENTRIES];
        logic [DATA_W-1:0] slot_value [NUM_ENTRIES];
        bit                slot_valid [NUM_ENTRIES];
        int unsigned       slot_rank  [NUM_ENTRIES];
        int unsigned       fill_count;
        int unsigned       capacity;
        t_reply            expected_replies[$];
        int                mismatches;

        function new();
            foreach (slot_valid[i]) begin
                slot_valid[i] = 0;
                slot_rank[i]  = 0;
            end
            fill_count = 0;
            capacity   = CAP_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            capacity = 32'(cap);
        endfunction

        // Move slot s to rank 0; valid entries ranked below limit age by one.
        function void make_newest(int s, int unsigned limit);
            int i;
            for (i = 0; i < NUM_ENTRIES; i++)
                if (i != s && slot_valid[i] && slot_rank[i] < limit)
                    slot_rank[i]++;
            slot_rank[s] = 0;
        endfunction

        function t_reply apply_access(t_op op, logic [DATA_W-1:0] key,
                                      logic [DATA_W-1:0] val);
            t_reply      r;
            int unsigned cap_eff;
            int unsigned oldest;
            int          slot;
            int          i;
            r.hit   = 1'b0;
            r.value = (op == OP_GET) ? MISS_VALUE : PUT_VALUE;
            cap_eff = (capacity > NUM_ENTRIES) ? NUM_ENTRIES : capacity;
            if (cap_eff == 0)
                return r;
            slot = -1;
            for (i = 0; i < NUM_ENTRIES; i++)
                if (slot < 0 && slot_valid[i] && slot_key[i] == key)
                    slot = i;
            if (slot >= 0) begin
                r.hit = 1'b1;
                if (op == OP_GET)
                    r.value = slot_value[slot];
                else
                    slot_value[slot] = val;
                make_newest(slot, slot_rank[slot]);
                return r;
            end
            if (op == OP_GET)
                return r;
            if (fill_count >= cap_eff) begin
                // Full (or capacity lowered): replace the least recent entry.
                oldest = 0;
                for (i = 0; i < NUM_ENTRIES; i++)
                    if (slot_valid[i] && (slot < 0 || slot_rank[i] > oldest)) begin
                        slot   = i;
                        oldest = slot_rank[i];
                    end
                slot_key[slot]   = key;
                slot_value[slot] = val;
                make_newest(slot, oldest);
            end else begin
                for (i = 0; i < NUM_ENTRIES; i++)
                    if (slot < 0 && !slot_valid[i])
                        slot = i;
                slot_valid[slot] = 1;
                slot_key[slot]   = key;
                slot_value[slot] = val;
                make_newest(slot, 32'hFFFF_FFFF);
                fill_count++;
            end
            return r;
        endfunction

        function void log_access(t_op op, logic [DATA_W-1:0] key, logic [DATA_W-1:0] val);
            expected_replies.push_back(apply_access(op, key, val));
        endfunction

        function void report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
        endfunction

        function void check_reply(logic hit, logic [DATA_W-1:0] value);
            t_reply want;
            if (expected_replies.size() == 0) begin
                report("unexpected result", '0, value);
                return;
            end
            want = expected_replies.pop_front();
            if (want.hit !== hit)
                report("hit", DATA_W'(want.hit), DATA_W'(hit));
            if (want.value !== value)
                report("read_value", want.value, value);
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CAP_W-1:0]    i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [2*DATA_W-1:0] s_axis_tdata;   // [31:0] key, [63:32] write_value
    logic                s_axis_tuser;   // [0] operation
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [DATA_W-1:0]   m_axis_tdata;   // [31:0] read_value
    logic                m_axis_tuser;   // [0] hit

    t_cache_scoreboard sb;
    int                src_idle_pct;
    int                sink_idle_pct;
    bit                hold_req;
    int                hold_left;
    int unsigned       cycle_count;
    logic [DATA_W-1:0] key_pool [POOL_SIZE];

    lru_key_value_cache dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_reply(m_axis_tuser, m_axis_tdata);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_access(input t_op op, input logic [DATA_W-1:0] key,
                               input logic [DATA_W-1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {val, key};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.log_access(op, key, val);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result has left the block.
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_replies.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_capacity(cap);
    endtask

    task automatic run_random(input int count, input int unsigned cap);
        int                span;
        int                n;
        t_op               op;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] val;
        // Keep the key pool a little wider than the capacity so that hits and
        // evictions both happen.
        span = (cap > NUM_ENTRIES) ? NUM_ENTRIES + 4 : cap + 4;
        if (span > POOL_SIZE)
            span = POOL_SIZE;
        for (n = 0; n < count; n++) begin
            op  = t_op'($urandom_range(1));
            key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(span - 1)] : $urandom;
            case ($urandom_range(19))
                0: val = 32'h8000_0000;
                1: val = 32'h7FFF_FFFF;
                2: val = 32'hFFFF_FFFF;
                3: val = 32'h0000_0000;
                default: val = $urandom;
            endcase
            push_access(op, key, val);
        end
    endtask

    initial begin
        int unsigned phase_cap [11];
        int          p;
        phase_cap = '{16, 1, 0, 5, 31, 3, 16, 8, 17, 2, 16};

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_GET;
        m_axis_tready = 1'b0;
        src_idle_pct  = 18;
        sink_idle_pct = 18;
        hold_req      = 0;
        hold_left     = 0;
        cycle_count   = 0;
        sb            = new();

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (p = 4; p < POOL_SIZE; p++)
            key_pool[p] = $urandom;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset capacity: empty store, extreme keys and values, update in place.
        push_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
        push_access(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        push_access(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        push_access(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_access(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        push_access(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        push_access(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
        push_access(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        push_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        push_access(OP_GET, 32'h0000_0000, 32'h0000_0000);

        // Disabled cache: gets miss, puts are dropped, contents kept.
        settle_idle();
        write_capacity(5'd0);
        push_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
        push_access(OP_PUT, 32'h0000_DEAD, 32'h0000_0001);
        push_access(OP_GET, 32'h0000_DEAD, 32'h0000_0000);

        // Capacity below the current fill: each new key evicts the oldest.
        settle_idle();
        write_capacity(5'd2);
        push_access(OP_PUT, 32'hAAAA_5555, 32'h5555_AAAA);
        push_access(OP_PUT, 32'h5555_AAAA, 32'hAAAA_5555);
        push_access(OP_GET, 32'hAAAA_5555, 32'h0000_0000);
        push_access(OP_PUT, 32'h0000_0001, 32'h0000_0002);
        push_access(OP_GET, 32'h5555_AAAA, 32'h0000_0000);
        push_access(OP_GET, 32'h8000_0000, 32'h0000_0000);

        // Capacity above the entry count saturates.
        settle_idle();
        write_capacity(5'd31);
        push_access(OP_PUT, 32'h0000_0001, 32'hCAFE_F00D);
        push_access(OP_GET, 32'h0000_0001, 32'h0000_0000);
        push_access(OP_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        push_access(OP_GET, 32'h0F0F_0F0F, 32'h0000_0000);

        for (p = 0; p < 11; p++) begin
            settle_idle();
            write_capacity(phase_cap[p][CAP_W-1:0]);
            src_idle_pct  = (p == 3) ? 0 : 18;
            sink_idle_pct = (p == 3) ? 0 : 18;
            // Stall the output for a long stretch so the input backs up.
            if (p == 6)
                hold_req = 1;
            run_random((phase_cap[p] == 0) ? 30 : 110, phase_cap[p]);
        end

        settle_idle();
        repeat (6) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache.sv
rtl/lkvc_checker.sv
tb/sv/lru_key_value_cache_tb.sv
